// File: rtl/core/bvpp_pkg.sv
// Shared types and constants for the boundary vector projection pattern block.
// Depends on nothing; every other file of the block imports it.
package bvpp_pkg;

	localparam int COORD_W   = 11;
	localparam int PROJ_W    = 27;
	localparam int OFS_W     = 2;
	localparam int SPAN_W    = 4;
	localparam int CNT_W     = 5;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 2;
	localparam int CNT_RESET = 16;

	localparam logic [ADDR_W-1:0] ADDR_POINT_COUNT = 2'd0;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t vx;
		coord_t vy;
		coord_t nx;
		coord_t ny;
	} point_t;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
	} job_t;

	typedef struct packed {
		logic pop;
		logic done;
	} back_ctl_t;

endpackage

// File: rtl/core/boundary_vector_projection_pattern_top.sv
// Top level of the boundary vector projection pattern block: configuration port,
// front end, job queue, point store and back end. Depends on bvpp_pkg and all bvpp_ modules.
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ------------------------------------------------
//  points    push / full                vec_x, vec_y, normal_x, normal_y
//  results   pop / empty                proj_x, proj_y, start_offset, span_length,
//                                       last_result
//  config    psel, penable, pwrite,     paddr, pwdata, prdata (point_count at byte 0)
//            pready
//
// The front end accepts a point transaction whenever full is low. The back end takes
// a set from the job queue while idle, then reads one store entry per cycle while its
// result queue has room: one extra read for each start offset, then one per result.
// Each read passes the read, sum and product registers before its result is queued.
// A full set of 16 points needs 58 reads for its 54 results, and the back end works
// on it overlapped with loading the next set into the other bank.
// Reset clears all control state; the point store itself is not cleared.
// The front end stalls (full high) only while both store banks hold sets still being
// worked on; the back end stalls only when its four-entry result queue is full.
module boundary_vector_projection_pattern_top import bvpp_pkg::*; #(
	parameter int MAX_POINTS   = 16,
	parameter int START_POINTS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     push,
	output logic                     full,
	input  logic signed [COORD_W-1:0] vec_x,
	input  logic signed [COORD_W-1:0] vec_y,
	input  logic signed [COORD_W-1:0] normal_x,
	input  logic signed [COORD_W-1:0] normal_y,

	output logic                     empty,
	input  logic                     pop,
	output logic signed [PROJ_W-1:0] proj_x,
	output logic signed [PROJ_W-1:0] proj_y,
	output logic [OFS_W-1:0]         start_offset,
	output logic [SPAN_W-1:0]        span_length,
	output logic                     last_result,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	localparam int AW = $clog2(MAX_POINTS) + 1;

	logic [CNT_W-1:0] point_count_q;

	back_ctl_t     back_ctl;
	logic [1:0]    pend;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	point_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	point_t        rd_data;
	logic          job_push;
	job_t          job_in;
	job_t          job_head;
	logic          job_empty;

	// The configuration port never inserts wait states. Writes land on the access
	// phase, and only the point count register is decoded.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_POINT_COUNT) ? DATA_W'(point_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(CNT_RESET);
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_POINT_COUNT)) begin
			point_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// The front end writes each point into the bank being filled and, on the
	// point that completes a set, hands the bank and its size to the job queue.
	bvpp_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.point_count (point_count_q),
		.back_ctl    (back_ctl),
		.pend        (pend),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.job_push    (job_push),
		.job         (job_in)
	);

	bvpp_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job_in),
		.back_ctl (back_ctl),
		.empty    (job_empty),
		.head     (job_head)
	);

	bvpp_store #(
		.MAX_POINTS (MAX_POINTS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The back end releases a bank as soon as its last entry has been read.
	bvpp_back #(
		.MAX_POINTS   (MAX_POINTS),
		.START_POINTS (START_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_empty    (job_empty),
		.job          (job_head),
		.ctl          (back_ctl),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.empty        (empty),
		.pop          (pop),
		.proj_x       (proj_x),
		.proj_y       (proj_y),
		.start_offset (start_offset),
		.span_length  (span_length),
		.last_result  (last_result)
	);

`ifndef SYNTHESIS
	// A set can only be finished by the back end if one has been handed over.
	a_done_needs_set: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.done |-> (pend != 2'd0))
		else $error("back end finished a set that was never handed over");

	// The bank being filled must never be one the back end still reads.
	a_no_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (pend != 2'd2))
		else $error("point written while both banks are in use");

	// The back end takes a job only when the queue holds one.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.pop |-> !job_empty)
		else $error("job queue read while empty");

	// A completed set always lifts the outstanding count by one unless one retires too.
	a_pend_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(job_push && !back_ctl.done) |=> (pend == $past(pend) + 2'd1))
		else $error("outstanding set count lost a completed set");
`endif

endmodule

// File: rtl/core/bvpp_front.sv
// Front end: takes point transactions, writes them to the store and raises a job per set.
// Depends on bvpp_pkg.
module bvpp_front import bvpp_pkg::*; #(
	parameter int MAX_POINTS = 16,
	localparam int IW = $clog2(MAX_POINTS),
	localparam int AW = IW + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  coord_t           vec_x,
	input  coord_t           vec_y,
	input  coord_t           normal_x,
	input  coord_t           normal_y,
	input  logic [CNT_W-1:0] point_count,
	input  back_ctl_t        back_ctl,
	output logic [1:0]       pend,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output point_t           wr_data,
	output logic             job_push,
	output job_t             job
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

	logic [IW-1:0]    load_q;
	logic             bank_q;
	logic [1:0]       pend_q;
	logic             accept;
	logic             complete;
	logic [CNT_W-1:0] n_eff;

	// Both banks are taken once two sets wait for, or are in, the back end.
	assign full   = (pend_q == 2'd2);
	assign pend   = pend_q;
	assign accept = push & ~full;

	always_comb begin
		n_eff = point_count;
		if (point_count > MAX_CNT) begin
			n_eff = MAX_CNT;
		end
		if (point_count == '0) begin
			n_eff = CNT_W'(1);
		end
	end

	assign complete = ((CNT_W'(load_q) + CNT_W'(1)) >= n_eff);

	assign wr_en    = accept;
	assign wr_addr  = {bank_q, load_q};
	assign wr_data  = '{vx: vec_x, vy: vec_y, nx: normal_x, ny: normal_y};
	assign job_push = accept & complete;
	assign job      = '{bank: bank_q, count: n_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			bank_q <= 1'b0;
			pend_q <= '0;
		end else begin
			if (accept) begin
				if (complete) begin
					load_q <= '0;
					bank_q <= ~bank_q;
				end else begin
					load_q <= load_q + 1'b1;
				end
			end
			case ({job_push, back_ctl.done})
				2'b10:   pend_q <= pend_q + 2'd1;
				2'b01:   pend_q <= pend_q - 2'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

endmodule

// File: rtl/core/bvpp_jobq.sv
// Two-entry queue of completed sets between the front end and the back end.
// Depends on bvpp_pkg.
module bvpp_jobq import bvpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  back_ctl_t back_ctl,
	output logic      empty,
	output job_t      head
);

	job_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rp_q];
	assign pop   = back_ctl.pop & ~empty;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/bvpp_store.sv
// Point store: two banks of points, one write and one registered read per cycle.
// Depends on bvpp_pkg.
module bvpp_store import bvpp_pkg::*; #(
	parameter int MAX_POINTS = 16,
	localparam int AW = $clog2(MAX_POINTS) + 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  point_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output point_t        rd_data
);

	localparam int DEPTH = 2 ** AW;

	point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/bvpp_back.sv
// Back end: walks each set over start offsets and spans, forms the projections
// and queues the results. Depends on bvpp_pkg.
module bvpp_back import bvpp_pkg::*; #(
	parameter int MAX_POINTS   = 16,
	parameter int START_POINTS = 4,
	localparam int IW = $clog2(MAX_POINTS),
	localparam int AW = IW + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_empty,
	input  job_t                     job,
	output back_ctl_t                ctl,
	output logic                     rd_en,
	output logic [AW-1:0]            rd_addr,
	input  point_t                   rd_data,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [PROJ_W-1:0] proj_x,
	output logic signed [PROJ_W-1:0] proj_y,
	output logic [OFS_W-1:0]         start_offset,
	output logic [SPAN_W-1:0]        span_length,
	output logic                     last_result
);

	localparam int SW = COORD_W + $clog2(MAX_POINTS - 1);
	localparam int PW = SW + COORD_W;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = $clog2(OQ_DEPTH);
	localparam logic [2:0] START_LIM = 3'(START_POINTS);

	typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

	typedef struct packed {
		logic signed [PROJ_W-1:0] px;
		logic signed [PROJ_W-1:0] py;
		logic [OFS_W-1:0]         ofs;
		logic [SPAN_W-1:0]        span;
		logic                     last;
	} result_t;

	seq_state_t       state_q;
	logic             bank_q;
	logic [CNT_W-1:0] n_q;
	logic [OFS_W-1:0] s_q;
	logic [IW-1:0]    e_q;

	logic             adv;
	logic             issue;
	logic             last_e;
	logic             next_s_ok;
	logic             set_end;

	// Read stage tags, aligned with the registered store data.
	logic              v_s1;
	logic              start_s1;
	logic [OFS_W-1:0]  s_s1;
	logic [SPAN_W-1:0] k_s1;
	logic              last_s1;

	// Running sums and the normal at the current start offset.
	logic signed [SW-1:0] sx_q, sy_q;
	logic signed [SW-1:0] sum_x, sum_y;
	coord_t               pvx_q, pvy_q, nsx_q, nsy_q;

	logic                 v_s2;
	logic signed [SW-1:0] sx_s2, sy_s2;
	coord_t               nex_s2, ney_s2, nsx_s2, nsy_s2;
	logic [OFS_W-1:0]     s_s2;
	logic [SPAN_W-1:0]    k_s2;
	logic                 last_s2;

	logic                 v_s3;
	logic signed [PW-1:0] pxa_s3, pxb_s3, pya_s3, pyb_s3;
	logic [OFS_W-1:0]     s_s3;
	logic [SPAN_W-1:0]    k_s3;
	logic                 last_s3;

	logic signed [PW:0]   sum_px, sum_py;
	result_t              res;

	result_t           oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  wp_q, rp_q;
	logic [OQ_AW:0]    ocnt_q;
	logic              oq_wr, oq_rd;

	// The whole pipeline moves together whenever the result queue has room.
	assign adv   = (ocnt_q != (OQ_AW+1)'(OQ_DEPTH));
	assign issue = (state_q == SEQ_RUN) & adv;

	assign last_e    = (CNT_W'(e_q) == (n_q - CNT_W'(1)));
	assign next_s_ok = ((3'(s_q) + 3'd1) < START_LIM) && ((CNT_W'(s_q) + CNT_W'(2)) < n_q);
	assign set_end   = issue & last_e & ~next_s_ok;

	assign ctl.pop  = (state_q == SEQ_IDLE) & ~job_empty;
	assign ctl.done = (ctl.pop & (job.count < CNT_W'(2))) | set_end;

	assign rd_en   = issue;
	assign rd_addr = {bank_q, e_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			bank_q  <= 1'b0;
			n_q     <= '0;
			s_q     <= '0;
			e_q     <= '0;
		end else begin
			unique case (state_q)
				SEQ_IDLE: begin
					if (!job_empty) begin
						bank_q <= job.bank;
						n_q    <= job.count;
						s_q    <= '0;
						e_q    <= '0;
						if (job.count >= CNT_W'(2)) begin
							state_q <= SEQ_RUN;
						end
					end
				end
				SEQ_RUN: begin
					if (adv) begin
						if (last_e) begin
							if (next_s_ok) begin
								s_q <= s_q + 1'b1;
								e_q <= IW'(s_q) + IW'(1);
							end else begin
								state_q <= SEQ_IDLE;
							end
						end else begin
							e_q <= e_q + 1'b1;
						end
					end
				end
				default: state_q <= SEQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1 & ~start_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			start_s1 <= (e_q == IW'(s_q));
			s_s1     <= s_q;
			k_s1     <= SPAN_W'(e_q - IW'(s_q));
			last_s1  <= last_e & ~next_s_ok;
		end
	end

	assign sum_x = sx_q + SW'(pvx_q);
	assign sum_y = sy_q + SW'(pvy_q);

	// The entry read for a span supplies its end normal and the vector added next.
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			pvx_q <= rd_data.vx;
			pvy_q <= rd_data.vy;
			if (start_s1) begin
				nsx_q <= rd_data.nx;
				nsy_q <= rd_data.ny;
				sx_q  <= '0;
				sy_q  <= '0;
			end else begin
				sx_q    <= sum_x;
				sy_q    <= sum_y;
				sx_s2   <= sum_x;
				sy_s2   <= sum_y;
				nex_s2  <= rd_data.nx;
				ney_s2  <= rd_data.ny;
				nsx_s2  <= nsx_q;
				nsy_s2  <= nsy_q;
				s_s2    <= s_s1;
				k_s2    <= k_s1;
				last_s2 <= last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			pxa_s3  <= PW'(sx_s2) * PW'(nsx_s2);
			pxb_s3  <= PW'(sy_s2) * PW'(nsy_s2);
			pya_s3  <= PW'(sx_s2) * PW'(nex_s2);
			pyb_s3  <= PW'(sy_s2) * PW'(ney_s2);
			s_s3    <= s_s2;
			k_s3    <= k_s2;
			last_s3 <= last_s2;
		end
	end

	assign sum_px = (PW+1)'(pxa_s3) + (PW+1)'(pxb_s3);
	assign sum_py = (PW+1)'(pya_s3) + (PW+1)'(pyb_s3);
	assign res    = '{px: PROJ_W'(sum_px), py: PROJ_W'(sum_py),
	                  ofs: s_s3, span: k_s3, last: last_s3};

	assign oq_wr = adv & v_s3;
	assign oq_rd = pop & ~empty;
	assign empty = (ocnt_q == '0);

	always_ff @(posedge clk) begin
		if (oq_wr) begin
			oq_q[wp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			ocnt_q <= '0;
		end else begin
			if (oq_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (oq_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({oq_wr, oq_rd})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assign proj_x       = oq_q[rp_q].px;
	assign proj_y       = oq_q[rp_q].py;
	assign start_offset = oq_q[rp_q].ofs;
	assign span_length  = oq_q[rp_q].span;
	assign last_result  = oq_q[rp_q].last;

endmodule

// File: verif/boundary_vector_projection_pattern_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for boundary_vector_projection_pattern_top: random point traffic
// against an in-bench prediction of the projection results. Depends on bvpp_pkg and the RTL.
module boundary_vector_projection_pattern_top_tb;
	import bvpp_pkg::*;

	localparam int MAX_PTS       = 16;
	localparam int START_PTS     = 4;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 7;
	// Time for the back end to finish a full set of 16 points, with a margin on top.
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_ITEMS  = 170;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_LIMIT   = 5000;

	// One projection result as it leaves the block.
	typedef struct packed {
		logic signed [PROJ_W-1:0] px;
		logic signed [PROJ_W-1:0] py;
		logic [OFS_W-1:0]         ofs;
		logic [SPAN_W-1:0]        span;
		logic                     is_last;
	} proj_result_t;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      push     = 1'b0;
	logic                      full;
	logic signed [COORD_W-1:0] vec_x    = '0;
	logic signed [COORD_W-1:0] vec_y    = '0;
	logic signed [COORD_W-1:0] normal_x = '0;
	logic signed [COORD_W-1:0] normal_y = '0;
	logic                      empty;
	logic                      pop      = 1'b0;
	logic signed [PROJ_W-1:0]  proj_x;
	logic signed [PROJ_W-1:0]  proj_y;
	logic [OFS_W-1:0]          start_offset;
	logic [SPAN_W-1:0]         span_length;
	logic                      last_result;
	logic                      psel     = 1'b0;
	logic                      penable  = 1'b0;
	logic                      pwrite   = 1'b0;
	logic [ADDR_W-1:0]         paddr    = '0;
	logic [DATA_W-1:0]         pwdata   = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	boundary_vector_projection_pattern_top #(
		.MAX_POINTS   (MAX_PTS),
		.START_POINTS (START_PTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.vec_x        (vec_x),
		.vec_y        (vec_y),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.empty        (empty),
		.pop          (pop),
		.proj_x       (proj_x),
		.proj_y       (proj_y),
		.start_offset (start_offset),
		.span_length  (span_length),
		.last_result  (last_result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Points still to be offered to the block, and projections it still owes us.
	point_t       points_to_send[$];
	proj_result_t projections[$];

	// Shadow copy of the block's state, kept up to date as point transactions are accepted.
	logic [CNT_W-1:0] cfg_points = CNT_W'(CNT_RESET);
	int               points_loaded = 0;
	coord_t           vx_mem[MAX_PTS];
	coord_t           vy_mem[MAX_PTS];
	coord_t           nx_mem[MAX_PTS];
	coord_t           ny_mem[MAX_PTS];

	int mismatches = 0;
	int cycle_count = 0;

	// Sender pacing and receiver stall pattern.
	int burst_left = 1;
	int gap_left   = 0;
	int pop_pct    = 100;
	int stall_tick = 0;

	proj_result_t want;

	// Variables of the stimulus sequence.
	int               idx;
	int               batch;
	int               random_sent = 0;
	int               drain_wait;
	int               new_count;
	logic [DATA_W-1:0] reg_value;

	task automatic flag_mismatch(string what);
		$display("MISMATCH (cycle %0d): %s", cycle_count, what);
		mismatches++;
	endtask

	// A count of zero behaves as one, and anything past the store depth as the full depth.
	function automatic int points_per_set(int cnt);
		if (cnt > MAX_PTS)
			return MAX_PTS;
		if (cnt == 0)
			return 1;
		return cnt;
	endfunction

	// Store one accepted point; when it closes a set, queue every projection of the set.
	function automatic void store_point_and_project(point_t p);
		int           n;
		int           slot;
		int           sx;
		int           sy;
		int           px;
		int           py;
		proj_result_t r;
		proj_result_t set_q[$];

		n = points_per_set(int'(cfg_points));
		slot = (points_loaded >= MAX_PTS) ? MAX_PTS - 1 : points_loaded;
		vx_mem[slot] = p.vx;
		vy_mem[slot] = p.vy;
		nx_mem[slot] = p.nx;
		ny_mem[slot] = p.ny;
		points_loaded = (points_loaded + 1) & 31;
		if (points_loaded < n)
			return;
		points_loaded = 0;

		for (int s = 0; s < START_PTS && s + 1 < n; s++) begin
			sx = 0;
			sy = 0;
			for (int k = 1; s + k < n; k++) begin
				sx += vx_mem[s + k - 1];
				sy += vy_mem[s + k - 1];
				px = sx * nx_mem[s] + sy * ny_mem[s];
				py = sx * nx_mem[s + k] + sy * ny_mem[s + k];
				r.px = px[PROJ_W-1:0];
				r.py = py[PROJ_W-1:0];
				r.ofs = OFS_W'(s);
				r.span = SPAN_W'(k);
				r.is_last = 1'b0;
				set_q.push_back(r);
			end
		end
		if (set_q.size() > 0)
			set_q[set_q.size() - 1].is_last = 1'b1;
		foreach (set_q[j])
			projections.push_back(set_q[j]);
	endfunction

	function automatic void queue_point(coord_t vx, coord_t vy, coord_t nx, coord_t ny);
		point_t p;

		p.vx = vx;
		p.vy = vy;
		p.nx = nx;
		p.ny = ny;
		points_to_send.push_back(p);
	endfunction

	// Mostly uniform over the whole range, with the two extremes turning up often.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return coord_t'(-1024);
			1: return coord_t'(1023);
			default: return coord_t'($urandom_range(0, 2047));
		endcase
	endfunction

	// Blocks until every point has been taken and every projection has come back, then
	// leaves the back end time to finish sets that yield nothing.
	task automatic wait_until_drained();
		while (points_to_send.size() != 0 || push || projections.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_read(output logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_POINT_COUNT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Changes the set size only once the block is quiet, then reads it back.
	task automatic set_point_count(int cnt);
		logic [DATA_W-1:0] rd;

		wait_until_drained();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_POINT_COUNT;
		pwdata  <= DATA_W'(cnt);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_points = CNT_W'(cnt);
		reg_read(rd);
		if (rd[CNT_W-1:0] !== cfg_points)
			flag_mismatch($sformatf("point_count read back %0d, wrote %0d", rd[CNT_W-1:0], cnt));
	endtask

	// Point driver. An accepted transaction is handed to the prediction straight away; a
	// refused one is held unchanged. Bursts of random length alternate with random gaps,
	// and some gaps are zero so that long unbroken stretches also occur.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push     <= 1'b0;
			vec_x    <= '0;
			vec_y    <= '0;
			normal_x <= '0;
			normal_y <= '0;
		end else begin
			if (push && !full)
				store_point_and_project(points_to_send.pop_front());
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (points_to_send.size() == 0) begin
					push <= 1'b0;
				end else begin
					push     <= 1'b1;
					vec_x    <= points_to_send[0].vx;
					vec_y    <= points_to_send[0].vy;
					normal_x <= points_to_send[0].nx;
					normal_y <= points_to_send[0].ny;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Result monitor. Each accepted result transaction is checked field by field against
	// the oldest outstanding projection. The receiver's willingness to pop switches at random
	// between always ready, light, medium and heavy back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (projections.size() == 0) begin
					flag_mismatch($sformatf("unexpected result s=%0d k=%0d x=%0d y=%0d",
						start_offset, span_length, proj_x, proj_y));
				end else begin
					want = projections.pop_front();
					if (proj_x !== want.px)
						flag_mismatch($sformatf("proj_x %0d, expected %0d (s=%0d k=%0d)",
							proj_x, want.px, want.ofs, want.span));
					if (proj_y !== want.py)
						flag_mismatch($sformatf("proj_y %0d, expected %0d (s=%0d k=%0d)",
							proj_y, want.py, want.ofs, want.span));
					if (start_offset !== want.ofs)
						flag_mismatch($sformatf("start_offset %0d, expected %0d",
							start_offset, want.ofs));
					if (span_length !== want.span)
						flag_mismatch($sformatf("span_length %0d, expected %0d (s=%0d)",
							span_length, want.span, want.ofs));
					if (last_result !== want.is_last)
						flag_mismatch($sformatf("last_result %0b, expected %0b (s=%0d k=%0d)",
							last_result, want.is_last, want.ofs, want.span));
				end
			end
			stall_tick++;
			if (stall_tick >= 50) begin
				stall_tick = 0;
				case ($urandom_range(0, 3))
					0: pop_pct = 100;
					1: pop_pct = 80;
					2: pop_pct = 50;
					default: pop_pct = 15;
				endcase
			end
			pop <= ($urandom_range(1, 100) <= pop_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("boundary_vector_projection_pattern_top verification failed");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// The register must come out of reset holding a full set size.
		reg_read(reg_value);
		if (reg_value[CNT_W-1:0] !== CNT_W'(CNT_RESET))
			flag_mismatch($sformatf("point_count after reset %0d", reg_value[CNT_W-1:0]));

		// Full set at the reset size, with largest-magnitude vectors and normals that flip sign
		// at every point: the sums reach their widest negative values, the products both signs.
		for (idx = 0; idx < MAX_PTS; idx++)
			queue_point((idx == MAX_PTS - 1) ? coord_t'(1023) : coord_t'(-1024),
				(idx == MAX_PTS - 1) ? coord_t'(1023) : coord_t'(-1024),
				idx[0] ? coord_t'(1023) : coord_t'(-1024),
				idx[0] ? coord_t'(1023) : coord_t'(-1024));

		// A zero count acts as one: every point closes an empty set.
		set_point_count(0);
		queue_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
		queue_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());

		// One point per set gives no span at all.
		set_point_count(1);
		queue_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());

		// Two points give a single result, which is also the last of its set.
		set_point_count(2);
		queue_point(coord_t'(1023), coord_t'(-1024), coord_t'(-1024), coord_t'(1023));
		queue_point(coord_t'(-1024), coord_t'(1023), coord_t'(1023), coord_t'(-1024));

		// Leave five points of a large set loaded, then shrink the set below that: the next
		// point must close the set using only the first three points.
		set_point_count(16);
		repeat (5) queue_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
		set_point_count(3);
		queue_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());

		// Random phases: mostly whole sets, sometimes a part-loaded set carried across a
		// change of size, with sizes from the empty cases up to counts past the store depth.
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: new_count = 16;
				1: new_count = 4;
				2: new_count = $urandom_range(17, 31);
				3: new_count = $urandom_range(0, 3);
				default: new_count = $urandom_range(4, 16);
			endcase
			set_point_count(new_count);
			batch = points_per_set(new_count) * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				batch += $urandom_range(1, 5);
			repeat (batch) queue_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			random_sent += batch;
		end

		// Let the sender run dry, give the results a bounded time to arrive, then settle.
		while (points_to_send.size() != 0 || push)
			@(posedge clk);
		drain_wait = 0;
		while (projections.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (projections.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived", projections.size()));

		if (mismatches == 0)
			$display("boundary_vector_projection_pattern_top verification clean");
		else
			$display("boundary_vector_projection_pattern_top verification failed");
		$finish;
	end

endmodule

// File: boundary_vector_projection_pattern_top.f
rtl/core/bvpp_pkg.sv
rtl/core/bvpp_front.sv
rtl/core/bvpp_jobq.sv
rtl/core/bvpp_store.sv
rtl/core/bvpp_back.sv
rtl/core/boundary_vector_projection_pattern_top.sv
verif/boundary_vector_projection_pattern_top_tb.sv
